FILE: design/obb_pkg.sv
package obb_pkg;

	localparam int COORD_BITS     = 24;
	localparam int AXIS_FRAC_BITS = 14;
	localparam int HALF_BITS      = COORD_BITS - 1;
	localparam int AXIS_BITS      = AXIS_FRAC_BITS + 2;
	localparam int T_BITS         = COORD_BITS + 1;
	// axis dot axis: sum of two AXIS_BITS products, magnitude
	localparam int DOT_BITS       = 2 * AXIS_BITS + 1;
	localparam int PROJ_BITS      = T_BITS + AXIS_BITS + 1;
	localparam int RTERM_BITS     = HALF_BITS + DOT_BITS;
	localparam int RAD_BITS       = RTERM_BITS + 2;
	localparam int DIST_BITS      = PROJ_BITS + AXIS_FRAC_BITS;
	localparam int QDEPTH         = 2;
	localparam int QPTR_BITS      = 1;

	localparam logic [2:0] SEP_AX   = 3'd0;
	localparam logic [2:0] SEP_AY   = 3'd1;
	localparam logic [2:0] SEP_BX   = 3'd2;
	localparam logic [2:0] SEP_BY   = 3'd3;
	localparam logic [2:0] SEP_NONE = 3'd4;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] a_center_x;
		logic signed [COORD_BITS-1:0] a_center_y;
		logic signed [AXIS_BITS-1:0]  a_axis_cos;
		logic signed [AXIS_BITS-1:0]  a_axis_sin;
		logic [HALF_BITS-1:0]         a_half_x;
		logic [HALF_BITS-1:0]         a_half_y;
		logic signed [COORD_BITS-1:0] b_center_x;
		logic signed [COORD_BITS-1:0] b_center_y;
		logic signed [AXIS_BITS-1:0]  b_axis_cos;
		logic signed [AXIS_BITS-1:0]  b_axis_sin;
		logic [HALF_BITS-1:0]         b_half_x;
		logic [HALF_BITS-1:0]         b_half_y;
	} obb_req_t;

	typedef struct packed {
		logic       overlap;
		logic [2:0] separating_axis;
	} obb_rsp_t;

	// front-end product set: everything the back end needs
	typedef struct packed {
		logic [HALF_BITS-1:0]         ahx;
		logic [HALF_BITS-1:0]         ahy;
		logic [HALF_BITS-1:0]         bhx;
		logic [HALF_BITS-1:0]         bhy;
		logic signed [PROJ_BITS-1:0]  tx_ac;
		logic signed [PROJ_BITS-1:0]  ty_as;
		logic signed [PROJ_BITS-1:0]  tx_as;
		logic signed [PROJ_BITS-1:0]  ty_ac;
		logic signed [PROJ_BITS-1:0]  tx_bc;
		logic signed [PROJ_BITS-1:0]  ty_bs;
		logic signed [PROJ_BITS-1:0]  tx_bs;
		logic signed [PROJ_BITS-1:0]  ty_bc;
		logic [DOT_BITS-1:0]          dot_c; // |Ax.Bx| = |Ay.By|
		logic [DOT_BITS-1:0]          dot_s; // |Ax.By| = |Ay.Bx|
		logic [DOT_BITS-1:0]          na;    // |A axis|^2
		logic [DOT_BITS-1:0]          nb;    // |B axis|^2
	} obb_work_t;

	typedef struct packed {
		logic [3:0] sep; // per-axis separated flags
	} obb_sep_t;

endpackage

FILE: design/obb_front.sv
module obb_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  obb_pkg::obb_req_t  req,
	output logic               wv,
	input  logic               wr,
	output obb_pkg::obb_work_t work
);
	import obb_pkg::*;

	// s1: center difference, operands registered; s2: products
	logic                         v_s1, v_s2;
	logic signed [T_BITS-1:0]     tx_s1, ty_s1;
	logic signed [AXIS_BITS-1:0]  ac_s1, as_s1, bc_s1, bs_s1;
	logic [HALF_BITS-1:0]         h_s1 [4];
	obb_work_t                    w_s2;
	logic                         adv1, adv2;

	logic signed [2*AXIS_BITS:0] dc, ds, da, db;

	assign adv2     = !v_s2 || wr;
	assign adv1     = !v_s1 || adv2;
	assign in_ready = adv1;
	assign wv       = v_s2;
	assign work     = w_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			tx_s1 <= T_BITS'(req.b_center_x) - T_BITS'(req.a_center_x);
			ty_s1 <= T_BITS'(req.b_center_y) - T_BITS'(req.a_center_y);
			ac_s1 <= req.a_axis_cos;
			as_s1 <= req.a_axis_sin;
			bc_s1 <= req.b_axis_cos;
			bs_s1 <= req.b_axis_sin;
			h_s1[0] <= req.a_half_x;
			h_s1[1] <= req.a_half_y;
			h_s1[2] <= req.b_half_x;
			h_s1[3] <= req.b_half_y;
		end
	end

	always_comb begin
		dc = (2*AXIS_BITS+1)'(ac_s1 * bc_s1) + (2*AXIS_BITS+1)'(as_s1 * bs_s1);
		ds = (2*AXIS_BITS+1)'(ac_s1 * bs_s1) - (2*AXIS_BITS+1)'(as_s1 * bc_s1);
		da = (2*AXIS_BITS+1)'(ac_s1 * ac_s1) + (2*AXIS_BITS+1)'(as_s1 * as_s1);
		db = (2*AXIS_BITS+1)'(bc_s1 * bc_s1) + (2*AXIS_BITS+1)'(bs_s1 * bs_s1);
	end

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			w_s2.ahx   <= h_s1[0];
			w_s2.ahy   <= h_s1[1];
			w_s2.bhx   <= h_s1[2];
			w_s2.bhy   <= h_s1[3];
			w_s2.tx_ac <= PROJ_BITS'(tx_s1 * ac_s1);
			w_s2.ty_as <= PROJ_BITS'(ty_s1 * as_s1);
			w_s2.tx_as <= PROJ_BITS'(tx_s1 * as_s1);
			w_s2.ty_ac <= PROJ_BITS'(ty_s1 * ac_s1);
			w_s2.tx_bc <= PROJ_BITS'(tx_s1 * bc_s1);
			w_s2.ty_bs <= PROJ_BITS'(ty_s1 * bs_s1);
			w_s2.tx_bs <= PROJ_BITS'(tx_s1 * bs_s1);
			w_s2.ty_bc <= PROJ_BITS'(ty_s1 * bc_s1);
			w_s2.dot_c <= dc[2*AXIS_BITS] ? DOT_BITS'(-dc) : DOT_BITS'(dc);
			w_s2.dot_s <= ds[2*AXIS_BITS] ? DOT_BITS'(-ds) : DOT_BITS'(ds);
			w_s2.na    <= DOT_BITS'(da);
			w_s2.nb    <= DOT_BITS'(db);
		end
	end

endmodule

FILE: design/obb_queue.sv
module obb_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wv,
	output logic               wr,
	input  obb_pkg::obb_work_t wdata,
	output logic               rv,
	input  logic               rr,
	output obb_pkg::obb_work_t rdata
);
	import obb_pkg::*;

	obb_work_t            mem_q [QDEPTH];
	logic [QPTR_BITS-1:0] wp_q, rp_q;
	logic [QPTR_BITS:0]   cnt_q;
	logic                 push, pop;

	assign wr    = (cnt_q != (QPTR_BITS+1)'(QDEPTH));
	assign rv    = (cnt_q != '0);
	assign rdata = mem_q[rp_q];
	assign push  = wv && wr;
	assign pop   = rv && rr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop)  rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

endmodule

FILE: design/obb_back.sv
module obb_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rv,
	output logic               rr,
	input  obb_pkg::obb_work_t work,
	output logic               out_valid,
	input  logic               out_ready,
	output obb_pkg::obb_rsp_t  rsp
);
	import obb_pkg::*;

	// s1: radius terms (ext * dot); s2: per-axis compare; s3: output reg
	logic                         v_s1, v_s2, v_s3;
	logic [RTERM_BITS-1:0]        rt_s1 [12];
	logic [PROJ_BITS-1:0]         pa_s1 [4];
	obb_sep_t                     sep_s2;
	obb_rsp_t                     rsp_s3;
	logic                         adv1, adv2, adv3;
	logic signed [PROJ_BITS-1:0]  p [4];
	logic [RAD_BITS-1:0]          rad [4];
	logic [DIST_BITS-1:0]         dv [4];

	assign adv3      = !v_s3 || out_ready;
	assign adv2      = !v_s2 || adv3;
	assign adv1      = !v_s1 || adv2;
	assign rr        = adv1;
	assign out_valid = v_s3;
	assign rsp       = rsp_s3;

	always_comb begin
		p[0] = work.tx_ac + work.ty_as;
		p[1] = work.ty_ac - work.tx_as;
		p[2] = work.tx_bc + work.ty_bs;
		p[3] = work.ty_bc - work.tx_bs;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= rv;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	// A.x: ahx*|A|^2, bhx*dc, bhy*ds   A.y: ahy*|A|^2, bhx*ds, bhy*dc
	// B.x: bhx*|B|^2, ahx*dc, ahy*ds   B.y: bhy*|B|^2, ahx*ds, ahy*dc
	always_ff @(posedge clk) begin
		if (adv1 && rv) begin
			rt_s1[0]  <= work.ahx * work.na;
			rt_s1[1]  <= work.ahy * work.na;
			rt_s1[2]  <= work.bhx * work.dot_c;
			rt_s1[3]  <= work.bhy * work.dot_s;
			rt_s1[4]  <= work.bhx * work.nb;
			rt_s1[5]  <= work.bhy * work.nb;
			rt_s1[6]  <= work.ahx * work.dot_c;
			rt_s1[7]  <= work.ahy * work.dot_s;
			rt_s1[8]  <= work.bhx * work.dot_s;
			rt_s1[9]  <= work.bhy * work.dot_c;
			rt_s1[10] <= work.ahx * work.dot_s;
			rt_s1[11] <= work.ahy * work.dot_c;
			for (int k = 0; k < 4; k++) begin
				pa_s1[k] <= p[k][PROJ_BITS-1] ? -p[k] : p[k];
			end
		end
	end

	always_comb begin
		rad[0] = RAD_BITS'(rt_s1[0]) + RAD_BITS'(rt_s1[2]) + RAD_BITS'(rt_s1[3]);
		rad[1] = RAD_BITS'(rt_s1[1]) + RAD_BITS'(rt_s1[8]) + RAD_BITS'(rt_s1[9]);
		rad[2] = RAD_BITS'(rt_s1[4]) + RAD_BITS'(rt_s1[6]) + RAD_BITS'(rt_s1[7]);
		rad[3] = RAD_BITS'(rt_s1[5]) + RAD_BITS'(rt_s1[10]) + RAD_BITS'(rt_s1[11]);
		for (int k = 0; k < 4; k++) begin
			dv[k] = {pa_s1[k], {AXIS_FRAC_BITS{1'b0}}};
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			for (int k = 0; k < 4; k++) begin
				sep_s2.sep[k] <= RAD_BITS'(dv[k]) > rad[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv3 && v_s2) begin
			rsp_s3.overlap <= (sep_s2.sep == 4'b0000);
			if (sep_s2.sep[0])      rsp_s3.separating_axis <= SEP_AX;
			else if (sep_s2.sep[1]) rsp_s3.separating_axis <= SEP_AY;
			else if (sep_s2.sep[2]) rsp_s3.separating_axis <= SEP_BX;
			else if (sep_s2.sep[3]) rsp_s3.separating_axis <= SEP_BY;
			else                    rsp_s3.separating_axis <= SEP_NONE;
		end
	end

endmodule

FILE: design/obb_overlap_test_2d_unit.sv
// channel | direction | handshake               | payload
// in      | request   | in_valid / in_ready     | in_data  (obb_req_t)
// out     | result    | out_valid / out_ready   | out_data (obb_rsp_t)
//
// One pair per cycle sustained while out_ready stays high. Front: center
// difference then the projection and axis dot products. Back: radius
// terms, four axis compares, priority pick.
// arst_n clears valid flags, queue pointers and queue count only.
// The two-entry queue lets the front keep taking requests while the back
// stalls on out_ready.
module obb_overlap_test_2d_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  obb_pkg::obb_req_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output obb_pkg::obb_rsp_t out_data
);
	import obb_pkg::*;

	logic      fv, fr, qv, qr;
	obb_work_t fw, qw;

	obb_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .req(in_data),
		.wv(fv), .wr(fr), .work(fw)
	);

	// decouples product front end from compare back end
	obb_queue u_queue (
		.clk, .arst_n, .wv(fv), .wr(fr), .wdata(fw),
		.rv(qv), .rr(qr), .rdata(qw)
	);

	obb_back u_back (
		.clk, .arst_n, .rv(qv), .rr(qr), .work(qw),
		.out_valid, .out_ready, .rsp(out_data)
	);

endmodule

FILE: design/obb_checker.sv
module obb_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input obb_pkg::obb_rsp_t out_data
);
	import obb_pkg::*;

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid)
		else $error("request withdrawn before accept");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result dropped while stalled");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.overlap == (out_data.separating_axis == SEP_NONE)))
		else $error("overlap and axis disagree");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.separating_axis <= SEP_NONE)
		else $error("bad axis code");

	a_noin: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> !out_valid)
		else $error("result out of reset");

endmodule

bind obb_overlap_test_2d_unit obb_checker u_obb_checker (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);
